// ----- rtl/image_mirror_flip_defines.svh -----
// Assertion macros shared by the mirror block.
`ifndef IMAGE_MIRROR_FLIP_DEFINES_SVH
`define IMAGE_MIRROR_FLIP_DEFINES_SVH

`ifndef SYNTHESIS

`define IMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define IMF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define IMF_ASSERT(lbl, prop, msg)

`define IMF_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ----- rtl/imf_pkg.sv -----
package imf_pkg;

  localparam int PIX_W          = 8;
  localparam int CFG_W          = 9;
  localparam int CFG_IDX_W      = 2;
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(256);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_FLIP_MODE    = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    MODE_LEFT_RIGHT = 1'b0,
    MODE_TOP_BOTTOM = 1'b1
  } imf_mode_t;

  typedef struct packed {
    logic accept;
    logic flush;
  } imf_step_t;

  typedef struct packed {
    logic valid;
    logic last;
  } imf_rd_t;

endpackage

// ----- rtl/imf_in_if.sv -----
interface imf_in_if;
  import imf_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             flush;

  modport source (output valid, output pixel_in, output flush, input ready);
  modport sink (input valid, input pixel_in, input flush, output ready);
endinterface

// ----- rtl/imf_out_if.sv -----
interface imf_out_if;
  import imf_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ----- rtl/imf_cfg_if.sv -----
interface imf_cfg_if;
  import imf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/imf_core.sv -----
`include "image_mirror_flip_defines.svh"

module imf_core #(
  parameter int MAX_WIDTH  = imf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = imf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  imf_pkg::imf_step_t                step,
  input  logic [imf_pkg::PIX_W-1:0]         pixel,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   eff_h,
  input  imf_pkg::imf_mode_t                mode,
  input  logic                              pop,
  output imf_pkg::imf_rd_t                  rd,
  output logic [imf_pkg::PIX_W-1:0]         rdata
);
  import imf_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int EWW   = $clog2(MAX_WIDTH + 1);
  localparam int EWH   = $clog2(MAX_HEIGHT + 1);
  localparam int AW    = 1 + RW + CW;
  localparam int DEPTH = 2 ** AW;

  logic [PIX_W-1:0] mem [DEPTH];

  logic [CW-1:0] wc, wc_next, rc, rc_next;
  logic [RW-1:0] wr, wr_next, rr, rr_next;
  logic          bank, bank_next;
  logic          pending, pending_next;
  logic          rd_valid_next;

  logic [EWW-1:0] w_m1;
  logic [EWH-1:0] h_m1;
  logic [CW-1:0]  wc_cl, rc_cl, sc;
  logic [RW-1:0]  wr_cl, rr_cl, sr;
  logic           rd_en, wr_en;
  logic           rd_col_end, rd_row_end, wr_col_end, wr_row_end;
  logic           rd_last;
  logic [AW-1:0]  raddr, waddr;

  assign w_m1 = eff_w - EWW'(1);
  assign h_m1 = eff_h - EWH'(1);

  assign rc_cl = (EWW'(rc) < eff_w) ? rc : CW'(w_m1);
  assign rr_cl = (EWH'(rr) < eff_h) ? rr : RW'(h_m1);
  assign wc_cl = (EWW'(wc) < eff_w) ? wc : CW'(w_m1);
  assign wr_cl = (EWH'(wr) < eff_h) ? wr : RW'(h_m1);

  assign rd_col_end = (rc_cl == CW'(w_m1));
  assign rd_row_end = (rr_cl == RW'(h_m1));
  assign wr_col_end = (wc_cl == CW'(w_m1));
  assign wr_row_end = (wr_cl == RW'(h_m1));
  assign rd_last    = rd_col_end && rd_row_end;

  assign sc = (mode == MODE_LEFT_RIGHT) ? CW'(w_m1) - rc_cl : rc_cl;
  assign sr = (mode == MODE_LEFT_RIGHT) ? rr_cl : RW'(h_m1) - rr_cl;

  assign raddr = {~bank, sr, sc};
  assign waddr = {bank, wr_cl, wc_cl};

  assign rd_en = step.accept && pending;
  assign wr_en = step.accept && !step.flush;

  always_comb begin
    rc_next      = rc;
    rr_next      = rr;
    wc_next      = wc;
    wr_next      = wr;
    bank_next    = bank;
    pending_next = pending;
    if (rd_en) begin
      if (rd_col_end) begin
        rc_next = '0;
        if (rd_row_end) begin
          rr_next      = '0;
          pending_next = 1'b0;
        end else begin
          rr_next = rr_cl + RW'(1);
        end
      end else begin
        rc_next = rc_cl + CW'(1);
        rr_next = rr_cl;
      end
    end
    if (wr_en) begin
      if (wr_col_end) begin
        wc_next = '0;
        if (wr_row_end) begin
          wr_next      = '0;
          bank_next    = ~bank;
          pending_next = 1'b1;
          rc_next      = '0;
          rr_next      = '0;
        end else begin
          wr_next = wr_cl + RW'(1);
        end
      end else begin
        wc_next = wc_cl + CW'(1);
        wr_next = wr_cl;
      end
    end
  end

  assign rd_valid_next = rd_en ? 1'b1 : (pop ? 1'b0 : rd.valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      wc       <= '0;
      wr       <= '0;
      rc       <= '0;
      rr       <= '0;
      bank     <= 1'b0;
      pending  <= 1'b0;
      rd.valid <= 1'b0;
    end else begin
      wc       <= wc_next;
      wr       <= wr_next;
      rc       <= rc_next;
      rr       <= rr_next;
      bank     <= bank_next;
      pending  <= pending_next;
      rd.valid <= rd_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= pixel;
    end
    if (rd_en) begin
      rdata   <= mem[raddr];
      rd.last <= rd_last;
    end
  end

  `IMF_ASSERT_NEVER(a_read_overrun, rd_en && rd.valid && !pop, "read issued over a held beat")
  `IMF_ASSERT(a_read_lands, rd_en |=> rd.valid, "issued read did not land")
  `IMF_ASSERT(a_frame_arms, (wr_en && wr_col_end && wr_row_end) |=> pending, "frame not armed")
  `IMF_ASSERT(a_bank_swap, (wr_en && wr_col_end && wr_row_end) |=> (bank != $past(bank)), "bank did not swap")

endmodule

// ----- rtl/image_mirror_flip.sv -----
// Mirrors a row-major stream of 8-bit grey pixels, one pixel per clock, using two frame
// banks in one on-chip memory of 2 * 2^ceil(log2(MAX_HEIGHT)) * 2^ceil(log2(MAX_WIDTH)) bytes.
// Each accepted beat stores its pixel (unless flush is set) into the bank being filled and, once
// a complete frame is waiting, reads the mirrored pixel of that frame from the other bank, so
// the output lags the input by one frame and keeps pace with it. Both memory accesses happen in the
// cycle of acceptance; a beat is taken every clock while the output drains. A result passes
// through the memory read register and then the output register. The memory needs no clearing
// pass after reset. The user must write configuration through the cfg channel while the stream
// is idle; the block does not enforce this. flip_mode 0 reverses each row, 1 swaps rows.
module image_mirror_flip #(
  parameter int MAX_WIDTH  = imf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = imf_pkg::MAX_HEIGHT_DEF
) (
  input logic      clk,
  input logic      rst,
  imf_cfg_if.sink  cfg,
  imf_in_if.sink   raw,
  imf_out_if.source mirrored
);
  import imf_pkg::*;

  localparam int EWW  = $clog2(MAX_WIDTH + 1);
  localparam int EWH  = $clog2(MAX_HEIGHT + 1);
  localparam int CMPW = (EWW > CFG_W) ? EWW : CFG_W;
  localparam int CMPH = (EWH > CFG_W) ? EWH : CFG_W;

  logic [CFG_W-1:0] frame_width, frame_height;
  imf_mode_t        flip_mode;

  logic [EWW-1:0]   eff_w;
  logic [EWH-1:0]   eff_h;
  logic [CMPW-1:0]  w_ext;
  logic [CMPH-1:0]  h_ext;

  imf_step_t        step;
  imf_rd_t          rd;
  logic [PIX_W-1:0] rdata;
  logic             pop;

  logic             out_valid;
  logic [PIX_W-1:0] out_pixel;
  logic             out_last;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      flip_mode    <= MODE_LEFT_RIGHT;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_FRAME_WIDTH:  frame_width  <= cfg.data;
        CFG_FRAME_HEIGHT: frame_height <= cfg.data;
        CFG_FLIP_MODE:    flip_mode    <= imf_mode_t'(cfg.data[0]);
        default: ;
      endcase
    end
  end

  assign w_ext = CMPW'(frame_width);
  assign h_ext = CMPH'(frame_height);

  assign eff_w = (frame_width == '0) ? EWW'(1) :
                 (w_ext > CMPW'(MAX_WIDTH)) ? EWW'(MAX_WIDTH) : EWW'(w_ext);
  assign eff_h = (frame_height == '0) ? EWH'(1) :
                 (h_ext > CMPH'(MAX_HEIGHT)) ? EWH'(MAX_HEIGHT) : EWH'(h_ext);

  assign pop       = rd.valid && (!out_valid || mirrored.ready);
  assign raw.ready = !rd.valid || !out_valid || mirrored.ready;

  assign step.accept = raw.valid && raw.ready;
  assign step.flush  = raw.flush;

  imf_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .pixel (raw.pixel_in),
    .eff_w (eff_w),
    .eff_h (eff_h),
    .mode  (flip_mode),
    .pop   (pop),
    .rd    (rd),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (mirrored.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_pixel <= rdata;
      out_last  <= rd.last;
    end
  end

  assign mirrored.valid      = out_valid;
  assign mirrored.pixel_out  = out_pixel;
  assign mirrored.frame_last = out_last;

endmodule

// ----- verif/image_mirror_flip_tb.sv -----
`timescale 1ns / 1ps

module image_mirror_flip_tb;
  import imf_pkg::*;

  localparam int MAX_W = MAX_WIDTH_DEF;
  localparam int MAX_H = MAX_HEIGHT_DEF;
  localparam int BANK_PIX = MAX_W * MAX_H;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             flush;
  } raw_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_last;
  } mirror_beat_t;

  logic clk;
  logic rst;

  imf_cfg_if cfg_if ();
  imf_in_if  raw_if ();
  imf_out_if out_if ();

  image_mirror_flip u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_if),
    .raw      (raw_if),
    .mirrored (out_if)
  );

  bit [PIX_W-1:0]   bank_pix [0:2*BANK_PIX-1];
  int unsigned      wr_col = 0;
  int unsigned      wr_row = 0;
  int unsigned      rd_col = 0;
  int unsigned      rd_row = 0;
  bit               wr_bank = 1'b0;
  bit               frame_ready = 1'b0;
  logic [CFG_W-1:0] width_reg = FRAME_WIDTH_RST;
  logic [CFG_W-1:0] height_reg = FRAME_HEIGHT_RST;
  imf_mode_t        mode_reg = MODE_LEFT_RIGHT;

  raw_beat_t    pending_beats [$];
  mirror_beat_t mirrored_q [$];
  int unsigned  beats_queued = 0;
  int unsigned  beats_taken = 0;
  int unsigned  mismatches = 0;
  int unsigned  phase_no = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct = 0;
  bit           in_fire = 1'b0;

  function automatic int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int unsigned clamp_pos(int unsigned v, int unsigned n);
    return (v < n) ? v : n - 1;
  endfunction

  function automatic void mirror_step(logic [PIX_W-1:0] pix, logic flush);
    int unsigned  w;
    int unsigned  h;
    int unsigned  c;
    int unsigned  r;
    int unsigned  src_row;
    int unsigned  src_col;
    mirror_beat_t beat;
    w = eff_size(width_reg, MAX_W);
    h = eff_size(height_reg, MAX_H);
    if (frame_ready) begin
      c = clamp_pos(rd_col, w);
      r = clamp_pos(rd_row, h);
      if (mode_reg == MODE_LEFT_RIGHT) begin
        src_row = r;
        src_col = w - 1 - c;
      end else begin
        src_row = h - 1 - r;
        src_col = c;
      end
      beat.pixel = bank_pix[(wr_bank ? 0 : BANK_PIX) + src_row * MAX_W + src_col];
      beat.frame_last = (r == h - 1) && (c == w - 1);
      mirrored_q.push_back(beat);
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) begin
          r = 0;
          frame_ready = 1'b0;
        end
      end
      rd_col = c;
      rd_row = r;
    end
    if (!flush) begin
      c = clamp_pos(wr_col, w);
      r = clamp_pos(wr_row, h);
      bank_pix[(wr_bank ? BANK_PIX : 0) + r * MAX_W + c] = pix;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) begin
          r = 0;
          wr_bank = !wr_bank;
          frame_ready = 1'b1;
          rd_col = 0;
          rd_row = 0;
        end
      end
      wr_col = c;
      wr_row = r;
    end
  endfunction

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin : watch_ports
    mirror_beat_t want;
    if (rst) begin
      in_fire = 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_FRAME_WIDTH: begin
            width_reg = cfg_if.data;
          end
          CFG_FRAME_HEIGHT: begin
            height_reg = cfg_if.data;
          end
          CFG_FLIP_MODE: begin
            mode_reg = imf_mode_t'(cfg_if.data[0]);
          end
          default: begin
          end
        endcase
      end
      in_fire = raw_if.valid && raw_if.ready;
      if (in_fire) begin
        mirror_step(raw_if.pixel_in, raw_if.flush);
        beats_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        if (mirrored_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected output beat: pixel %02h last %0b",
                     out_if.pixel_out, out_if.frame_last);
          end
          mismatches++;
        end else begin
          want = mirrored_q.pop_front();
          if (want.pixel !== out_if.pixel_out || want.frame_last !== out_if.frame_last) begin
            if (mismatches < 10) begin
              $display("mismatch: expected pixel %02h last %0b, got pixel %02h last %0b",
                       want.pixel, want.frame_last, out_if.pixel_out, out_if.frame_last);
            end
            mismatches++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin : drive_raw
    raw_beat_t nxt;
    if (rst) begin
      raw_if.valid <= 1'b0;
    end else if (!raw_if.valid || in_fire) begin
      if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_beats.pop_front();
        raw_if.valid <= 1'b1;
        raw_if.pixel_in <= nxt.pixel;
        raw_if.flush <= nxt.flush;
      end else begin
        raw_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_if.ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  task automatic queue_beat(logic [PIX_W-1:0] pix, logic fl);
    raw_beat_t b;
    b.pixel = pix;
    b.flush = fl;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (beats_taken != beats_queued || mirrored_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = val;
    do @(posedge clk);
    while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic configure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, imf_mode_t m);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_FLIP_MODE, CFG_W'(m));
    case (phase_no % 4)
      0: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      1: begin
        send_idle_pct = 68;
        stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct = 68;
      end
      default: begin
        send_idle_pct = 20;
        stall_pct = 20;
      end
    endcase
    phase_no++;
  endtask

  task automatic queue_frames(int unsigned frames, int unsigned flush_pct,
                              output int unsigned pixels);
    int unsigned n;
    n = frames * eff_size(width_reg, MAX_W) * eff_size(height_reg, MAX_H);
    for (int unsigned i = 0; i < n; i++) begin
      while ($urandom_range(99) < flush_pct) begin
        queue_beat(PIX_W'($urandom), 1'b1);
      end
      queue_beat(PIX_W'($urandom), 1'b0);
    end
    pixels = n;
  endtask

  // Finish the frame being written, then flush until the mirrored frame has drained.
  task automatic drain_frames();
    int unsigned w;
    int unsigned h;
    int unsigned rest;
    wait_drained();
    w = eff_size(width_reg, MAX_W);
    h = eff_size(height_reg, MAX_H);
    rest = 0;
    if (wr_col != 0 || wr_row != 0) begin
      rest = w * h - (clamp_pos(wr_row, h) * w + clamp_pos(wr_col, w));
    end
    for (int unsigned i = 0; i < rest; i++) begin
      queue_beat(PIX_W'($urandom), 1'b0);
    end
    for (int unsigned i = 0; i < w * h; i++) begin
      queue_beat(PIX_W'($urandom), 1'b1);
    end
    wait_drained();
  endtask

  initial begin
    int unsigned random_pixels;
    int unsigned got;
    logic [CFG_W-1:0] dims [2];
    rst = 1'b1;
    raw_if.valid = 1'b0;
    raw_if.pixel_in = '0;
    raw_if.flush = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_FRAME_WIDTH;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    configure(CFG_W'(3), CFG_W'(2), MODE_LEFT_RIGHT);
    queue_beat(8'h00, 1'b1);
    queue_beat(8'h00, 1'b0);
    queue_beat(8'hFF, 1'b0);
    queue_beat(8'h55, 1'b0);
    queue_beat(8'hAA, 1'b0);
    queue_beat(8'h01, 1'b0);
    queue_beat(8'h80, 1'b0);
    queue_beat(8'hFF, 1'b1);
    queue_beat(8'h7F, 1'b0);
    queue_beat(8'hFE, 1'b0);
    queue_beat(8'h0F, 1'b0);
    queue_beat(8'hF0, 1'b0);
    queue_beat(8'h33, 1'b0);
    queue_beat(8'hCC, 1'b0);
    drain_frames();

    configure(CFG_W'(0), CFG_W'(1), MODE_TOP_BOTTOM);
    queue_beat(8'h00, 1'b0);
    queue_beat(8'hFF, 1'b0);
    queue_beat(8'h12, 1'b1);
    queue_beat(8'h5A, 1'b0);
    drain_frames();

    // An oversized width is held at the widest row; read part of it, then shrink the row.
    configure(9'h1FF, CFG_W'(1), MODE_LEFT_RIGHT);
    queue_frames(1, 0, got);
    for (int i = 0; i < 6; i++) begin
      queue_beat(PIX_W'($urandom), 1'b1);
    end
    wait_drained();
    write_reg(CFG_FRAME_WIDTH, CFG_W'(4));
    drain_frames();

    // Shrink the frame and then change the mode while a frame is half written.
    configure(CFG_W'(6), CFG_W'(5), MODE_LEFT_RIGHT);
    for (int i = 0; i < 47; i++) begin
      queue_beat(PIX_W'($urandom), 1'b0);
    end
    wait_drained();
    write_reg(CFG_FRAME_WIDTH, CFG_W'(4));
    write_reg(CFG_FRAME_HEIGHT, CFG_W'(3));
    for (int i = 0; i < 5; i++) begin
      queue_beat(PIX_W'($urandom), 1'b0);
    end
    wait_drained();
    write_reg(CFG_FLIP_MODE, CFG_W'(MODE_TOP_BOTTOM));
    for (int i = 0; i < 7; i++) begin
      queue_beat(PIX_W'($urandom), 1'b0);
    end
    drain_frames();

    random_pixels = 0;
    while (random_pixels < 60) begin
      for (int k = 0; k < 2; k++) begin
        case ($urandom_range(9))
          0: begin
            dims[k] = '0;
          end
          1: begin
            dims[k] = CFG_W'($urandom_range(16, 9));
          end
          default: begin
            dims[k] = CFG_W'($urandom_range(8, 1));
          end
        endcase
      end
      configure(dims[0], dims[1], imf_mode_t'($urandom_range(1)));
      queue_frames($urandom_range(3, 2), $urandom_range(30), got);
      random_pixels += got;
      drain_frames();
    end

    repeat (20) @(negedge clk);
    if (mismatches == 0 && mirrored_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/imf_pkg.sv
rtl/imf_in_if.sv
rtl/imf_out_if.sv
rtl/imf_cfg_if.sv
rtl/imf_core.sv
rtl/image_mirror_flip.sv
verif/image_mirror_flip_tb.sv
